// ===== design/pal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg
// Shared widths, codes and controller/datapath interface types for the
// positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

  // Default list capacity (entries)
  localparam int CAPACITY_DEF = 64;

  // Fixed field widths
  localparam int TYPE_W = 2;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;

  // Request kinds
  localparam logic [TYPE_W-1:0] REQ_READ   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_DELETE = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic req_load;   // capture accepted request word
    logic chk_load;   // capture check status before the count moves
    logic idx_load;   // start shift index for insert/delete
    logic rd_pos;     // read store at position-1
    logic rd_shift;   // read shift source entry
    logic wr_shift;   // write shifted word at index
    logic wr_word;    // write inserted word at index
    logic cnt_inc;    // fill count + 1
    logic cnt_dec;    // fill count - 1
    logic out_load;   // load result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [TYPE_W-1:0] kind;  // latched request kind
    logic              ok;    // request passes range/full checks
    logic              more;  // shift loop has entries left
  } stat_t;

endpackage

// ===== design/pal_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_ctrl
// Sequencer for the positional array list: decodes a request, steps the
// shift loop one entry at a time (read, then write) and hands results to the output stage.
// ----------------------------------------------------------------------------
module pal_ctrl
  import pal_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_SH_WR = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.chk_load = 1'b1;
        state_nxt    = S_DONE;
        if (stat.ok) begin
          case (stat.kind) inside
            REQ_READ: cmd.rd_pos = 1'b1;
            REQ_INSERT, REQ_DELETE: begin
              cmd.idx_load = 1'b1;
              state_nxt    = S_SHIFT;
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        if (stat.more) begin
          cmd.rd_shift = 1'b1;
          state_nxt    = S_SH_WR;
        end else begin
          // loop finished: place the new word or shrink the list
          if (stat.kind == REQ_INSERT) begin
            cmd.wr_word = 1'b1;
            cmd.cnt_inc = 1'b1;
          end else begin
            cmd.cnt_dec = 1'b1;
          end
          state_nxt = S_DONE;
        end
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = S_SHIFT;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/pal_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_dp
// Datapath: request register, list store memory, fill count, shift index,
// range checks and result register.
// ----------------------------------------------------------------------------
module pal_dp
  import pal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [TYPE_W-1:0]        in_req_type,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [ST_W-1:0]          out_status,
  output logic [POS_W-1:0]         out_count,
  input  cmd_t                     cmd,
  output stat_t                    stat
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [TYPE_W-1:0]        req_type_r;
  logic [POS_W-1:0]         pos_r;
  logic [DATA_W-1:0]        value_r;
  logic [CW-1:0]            fill_r;
  logic [AW-1:0]            idx_r;
  logic [DATA_W-1:0]        mem [CAPACITY];
  logic [DATA_W-1:0]        rdata_r;
  logic [ST_W-1:0]          st_chk_r;
  logic [DATA_W-1:0]        rd_val_r;
  logic [ST_W-1:0]          st_out_r;
  logic [POS_W-1:0]         cnt_out_r;

  logic [EW-1:0]   pos_e, fill_e, idx_e;
  logic            pos_zero, in_list, ins_range_ok, is_full;
  logic [ST_W-1:0] status;
  logic [AW-1:0]   raddr, src_idx;
  logic [DATA_W-1:0] wdata;
  logic [CW-1:0]   fill_nxt;

  assign pos_e = EW'(pos_r);
  assign fill_e = EW'(fill_r);
  assign idx_e = EW'(idx_r);

  // Range and full checks
  assign pos_zero     = (pos_r == '0);
  assign in_list      = !pos_zero && (pos_e <= fill_e);
  assign ins_range_ok = !pos_zero && (pos_e <= fill_e + EW'(1));
  assign is_full      = (fill_e >= EW'(CAPACITY));

  always_comb begin
    unique case (req_type_r)
      REQ_READ:   status = in_list ? ST_OK : ST_RANGE;
      REQ_INSERT: status = !ins_range_ok ? ST_RANGE : (is_full ? ST_FULL : ST_OK);
      REQ_DELETE: status = in_list ? ST_OK : ST_RANGE;
      default:    status = ST_RANGE;
    endcase
  end

  // Loop status: insert walks down to the position, delete up to count-1
  assign stat.kind = req_type_r;
  assign stat.ok   = (status == ST_OK);
  assign stat.more = (req_type_r == REQ_INSERT) ? (idx_e >= pos_e)
                                                : ((idx_e + EW'(1)) < fill_e);

  // Store addresses and write data
  assign src_idx = (req_type_r == REQ_INSERT) ? (idx_r - AW'(1)) : (idx_r + AW'(1));
  assign raddr   = cmd.rd_pos ? AW'(pos_e - EW'(1)) : src_idx;
  assign wdata   = cmd.wr_word ? value_r : rdata_r;

  // Request register
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_type_r <= in_req_type;
      pos_r      <= in_position;
      value_r    <= in_value;
    end
  end

  // Status as checked against the count before the request
  always_ff @(posedge clk) begin
    if (cmd.chk_load) begin
      st_chk_r <= status;
    end
  end

  // Shift index
  always_ff @(posedge clk) begin
    if (cmd.idx_load) begin
      idx_r <= (req_type_r == REQ_INSERT) ? AW'(fill_r) : AW'(pos_e - EW'(1));
    end else if (cmd.wr_shift) begin
      idx_r <= (req_type_r == REQ_INSERT) ? (idx_r - AW'(1)) : (idx_r + AW'(1));
    end
  end

  // List store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_shift || cmd.wr_word) begin
      mem[idx_r] <= wdata;
    end
    if (cmd.rd_pos || cmd.rd_shift) begin
      rdata_r <= mem[raddr];
    end
  end

  // Fill count
  always_comb begin
    fill_nxt = fill_r;
    if (cmd.cnt_inc) begin
      fill_nxt = fill_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rd_val_r  <= ((req_type_r == REQ_READ) && (st_chk_r == ST_OK)) ? rdata_r : '0;
      st_out_r  <= st_chk_r;
      cnt_out_r <= fill_e[POS_W-1:0];
    end
  end

  assign out_read_value = rd_val_r;
  assign out_status     = st_out_r;
  assign out_count      = cnt_out_r;

endmodule

// ===== design/positional_array_list.sv =====
`timescale 1ns / 1ps
// Reads and rejected requests pass through the check and done states;
// inserts and deletes also step the shift loop once per moved entry.
// Throughput: one request at a time; the next is taken in the cycle after
// the result is loaded. Shifts move one entry at a time, a read then a
// write, over the store's write port and registered read port.
// Reset: fill count and control cleared; store contents stay undefined.
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of signed 32-bit words with positional read, insert and
// delete; controller and datapath around a one-write, one-read list store.
// ----------------------------------------------------------------------------
module positional_array_list
  import pal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [TYPE_W-1:0]        in_req_type,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [ST_W-1:0]          out_status,
  output logic [POS_W-1:0]         out_count
);

  cmd_t  cmd;
  stat_t stat;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count      (out_count),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

// ===== design/pal_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_checker
// Port-level checks for the positional array list, bound to the top level.
// ----------------------------------------------------------------------------
module pal_checker
  import pal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_read_value,
  input logic [ST_W-1:0]          out_status,
  input logic [POS_W-1:0]         out_count
);

  // Held result word stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value)
      && $stable(out_status) && $stable(out_count))
    else $error("result word changed while stalled");

  // One request in flight: no new word right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  // Rejected requests carry a zero read value
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_read_value == '0)
    else $error("nonzero read value on rejected request");

  // Status is a defined code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_RANGE)
      || (out_status == ST_FULL))
    else $error("undefined status code");

  // Count never exceeds capacity (where it fits the count field)
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY > 127) || (int'(out_count) <= CAPACITY))
    else $error("count above capacity");

endmodule

bind positional_array_list pal_checker #(
  .CAPACITY (CAPACITY)
) u_pal_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_value (out_read_value),
  .out_status     (out_status),
  .out_count      (out_count)
);

// ===== bench/positional_array_list_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_tb
// Self-checking bench for the positional array list. A queue-based model of
// the list predicts status, read value and count for every request word;
// a checker compares each result word against the oldest prediction.
// Stimulus: directed edge cases, a fill-to-full pass, back-pressure bursts
// and random insert/delete/read walks under varying valid/ready idling.
// ----------------------------------------------------------------------------
module positional_array_list_tb
  import pal_pkg::*;
();

  localparam int LIST_DEPTH    = CAPACITY_DEF;
  localparam int RESET_CYCLES  = 9;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 140;
  localparam int MAX_REPORTS   = 10;

  // Request code with no defined operation
  localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [ST_W-1:0]          status;
    logic [POS_W-1:0]         count;
  } reply_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [TYPE_W-1:0]        in_req_type = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_read_value;
  logic [ST_W-1:0]          out_status;
  logic [POS_W-1:0]         out_count;

  // Model of the list contents and the replies still owed
  logic signed [DATA_W-1:0] list_model[$];
  reply_t                   pending_replies[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  // Hold-off requests from the tests; served by the receiver
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;

  always #6 clk = ~clk;

  positional_array_list #(
    .CAPACITY(LIST_DEPTH)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count      (out_count)
  );

  // Update the list model for one request and return the reply it owes
  function automatic reply_t apply_request(input logic [TYPE_W-1:0] kind,
                                           input logic [POS_W-1:0] pos,
                                           input logic signed [DATA_W-1:0] word);
    reply_t r;
    int     p;
    int     n;
    p = int'(pos);
    n = list_model.size();
    r.read_value = '0;
    r.status     = ST_OK;
    case (kind)
      REQ_READ: begin
        if (p >= 1 && p <= n) r.read_value = list_model[p-1];
        else r.status = ST_RANGE;
      end
      REQ_INSERT: begin
        // range check wins over the full check
        if (p < 1 || p > n + 1) r.status = ST_RANGE;
        else if (n >= LIST_DEPTH) r.status = ST_FULL;
        else list_model.insert(p - 1, word);
      end
      REQ_DELETE: begin
        if (p < 1 || p > n) r.status = ST_RANGE;
        else list_model.delete(p - 1);
      end
      default: r.status = ST_RANGE;
    endcase
    r.count = POS_W'(list_model.size());
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request word, holding it until accepted
  task automatic send_request(input logic [TYPE_W-1:0] kind,
                              input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] word);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_position <= pos;
    in_value    <= word;
    do @(posedge clk); while (!in_ready);
    pending_replies.push_back(apply_request(kind, pos, word));
  endtask

  // Sender goes quiet until every reply has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Mostly well-formed requests against the current list, some noise
  task automatic send_random_request(input int ins_pct, input int del_pct);
    int               n;
    int               roll;
    int               noise;
    logic [TYPE_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    n     = list_model.size();
    roll  = $urandom_range(99);
    noise = $urandom_range(99);
    if (roll < ins_pct) kind = REQ_INSERT;
    else if (roll < ins_pct + del_pct) kind = REQ_DELETE;
    else kind = REQ_READ;
    if (noise < 4) begin
      kind = REQ_UNKNOWN;
      pos  = POS_W'($urandom_range(127));
    end else if (noise < 12) begin
      pos = POS_W'($urandom_range(127));
    end else if (noise < 16) begin
      // just past the legal range, or zero
      if ($urandom_range(1)) pos = '0;
      else pos = (kind == REQ_INSERT) ? POS_W'(n + 2) : POS_W'(n + 1);
    end else if (kind == REQ_INSERT) begin
      pos = POS_W'($urandom_range(1, n + 1));
    end else begin
      pos = (n == 0) ? POS_W'(1) : POS_W'($urandom_range(1, n));
    end
    send_request(kind, pos, pick_word());
  endtask

  // Edge cases on a small list
  task automatic test_directed();
    send_request(REQ_READ, 1, 0);
    send_request(REQ_DELETE, 1, 0);
    send_request(REQ_INSERT, 0, 32'h1234_5678);
    send_request(REQ_INSERT, 2, 32'h1234_5678);
    send_request(REQ_INSERT, 1, 32'h7FFF_FFFF);
    send_request(REQ_INSERT, 1, 32'h8000_0000);
    send_request(REQ_INSERT, 3, 32'h0000_0000);
    send_request(REQ_INSERT, 2, 32'hFFFF_FFFF);
    for (int p = 1; p <= 4; p++) send_request(REQ_READ, POS_W'(p), 0);
    send_request(REQ_READ, 0, 0);
    send_request(REQ_READ, 5, 0);
    send_request(REQ_READ, 127, 32'h5555_AAAA);
    send_request(REQ_UNKNOWN, 1, 32'hAAAA_5555);
    send_request(REQ_INSERT, 127, 32'h0F0F_F0F0);
    send_request(REQ_DELETE, 0, 0);
    send_request(REQ_DELETE, 5, 0);
    send_request(REQ_DELETE, 127, 0);
    send_request(REQ_DELETE, 2, 0);
    send_request(REQ_DELETE, 3, 0);
    send_request(REQ_DELETE, 1, 0);
    send_request(REQ_READ, 1, 0);
    wait_drained();
  endtask

  // Fill to capacity, then poke the full-list boundary
  task automatic test_full_list();
    while (list_model.size() < LIST_DEPTH)
      send_request(REQ_INSERT, POS_W'($urandom_range(1, list_model.size() + 1)),
                   pick_word());
    send_request(REQ_INSERT, POS_W'(LIST_DEPTH + 1), pick_word());
    send_request(REQ_INSERT, 1, pick_word());
    send_request(REQ_INSERT, POS_W'(LIST_DEPTH + 2), pick_word());
    send_request(REQ_READ, POS_W'(LIST_DEPTH), 0);
    send_request(REQ_READ, 1, 0);
    send_request(REQ_DELETE, POS_W'(LIST_DEPTH), 0);
    send_request(REQ_INSERT, 1, pick_word());
    wait_drained();
  endtask

  // Receiver stalls for a long stretch while requests keep coming
  task automatic test_back_pressure();
    hold_asked = hold_asked + 1;
    repeat (12) send_random_request(40, 40);
    wait_drained();
  endtask

  // Random walk: grow, churn, then shrink the list
  task automatic test_random_mix(input int num_words);
    repeat (num_words * 2 / 5) send_random_request(75, 10);
    repeat (num_words / 4) send_random_request(40, 40);
    repeat (num_words - num_words * 2 / 5 - num_words / 4) send_random_request(10, 75);
    wait_drained();
  endtask

  // Result channel ready, with random stalls and test-requested hold-offs
  always @(posedge clk) begin
    if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic note_mismatch(input string msg);
    mismatch_count = mismatch_count + 1;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  // Compare each result word against the oldest prediction
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        note_mismatch($sformatf("unexpected result: value %0d status %0d count %0d",
                                out_read_value, out_status, out_count));
      end else begin
        want = pending_replies.pop_front();
        if (out_read_value !== want.read_value || out_status !== want.status ||
            out_count !== want.count)
          note_mismatch($sformatf(
            "result: exp value %0d status %0d count %0d, got value %0d status %0d count %0d",
            want.read_value, want.status, want.count,
            out_read_value, out_status, out_count));
      end
    end
  end

  // Watchdog: give up after a long stretch with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender light idling, receiver heavy
    set_idling(21, 66);
    test_directed();
    test_full_list();
    test_back_pressure();
    test_random_mix(310);

    // sender heavy idling, receiver light
    set_idling(66, 21);
    test_random_mix(310);
    test_back_pressure();

    // full rate both sides
    set_idling(0, 0);
    test_random_mix(310);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/pal_pkg.sv
design/pal_ctrl.sv
design/pal_dp.sv
design/positional_array_list.sv
design/pal_checker.sv
bench/positional_array_list_tb.sv
